FILE: design/format_string_printer_defines.svh
// assertion macros shared by the formatter modules
`ifndef FORMAT_STRING_PRINTER_DEFINES_SVH
`define FORMAT_STRING_PRINTER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define FSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fsp_pkg.sv
package fsp_pkg;

  localparam int OFFSET_WIDTH = 16;
  localparam int CHAR_W       = 8;
  localparam int ARG_W        = 32;
  localparam int POS_W        = 16;
  localparam int SIZE_W       = 16;
  localparam int BCD_DIGITS   = 10;
  localparam int BCD_W        = 4 * BCD_DIGITS;

  typedef logic [OFFSET_WIDTH-1:0] offset_t;
  typedef logic [CHAR_W-1:0]       char_t;

  // pending specifier kinds
  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_HEX   = 2'd2;
  localparam logic [1:0] KIND_SHORT = 2'd3;

  // format characters
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_PCT   = 8'h25;
  localparam char_t CH_H     = 8'h68;
  localparam char_t CH_X_LO  = 8'h78;
  localparam char_t CH_X_UP  = 8'h58;
  localparam char_t CH_I     = 8'h69;
  localparam char_t CH_C     = 8'h63;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_A_LO  = 8'h61;
  localparam char_t CH_A_UP  = 8'h41;

  // one hex or decimal digit to ascii
  function automatic char_t digit_char(input logic [3:0] nib, input logic upper);
    char_t base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (nib < 4'd10) begin
      return CH_ZERO + {4'b0000, nib};
    end
    return base + {4'b0000, nib} - 8'd10;
  endfunction

endpackage

FILE: design/fsp_req_if.sv
interface fsp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [fsp_pkg::CHAR_W-1:0]   format_char;
  logic [fsp_pkg::ARG_W-1:0]    argument;

  modport source (output valid, operation, format_char, argument, input ready);
  modport sink   (input valid, operation, format_char, argument, output ready);
endinterface

FILE: design/fsp_res_if.sv
interface fsp_res_if;
  logic                         valid;
  logic                         ready;
  logic [fsp_pkg::CHAR_W-1:0]   out_char;
  logic                         stored;
  logic [fsp_pkg::POS_W-1:0]    position;
  logic [fsp_pkg::ARG_W-1:0]    total_count;
  logic                         is_terminator;
  logic                         last;

  modport source (output valid, out_char, stored, position, total_count, is_terminator,
                  last, input ready);
  modport sink   (input valid, out_char, stored, position, total_count, is_terminator,
                  last, output ready);
endinterface

FILE: design/fsp_bcd.sv
`include "format_string_printer_defines.svh"

// binary to bcd, one shift-and-add-3 step per cycle
module fsp_bcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fsp_pkg::ARG_W-1:0]  value_i,
  output logic                       done_o,
  output logic [fsp_pkg::BCD_W-1:0]  bcd_o
);

  logic [fsp_pkg::ARG_W-1:0] bin_q;
  logic [fsp_pkg::BCD_W-1:0] bcd_q;
  logic [fsp_pkg::BCD_W-1:0] adj;
  logic [4:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;

  always_comb begin
    for (int i = 0; i < fsp_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      bin_q  <= '0;
      bcd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        bin_q  <= value_i;
        bcd_q  <= '0;
      end else if (busy_q) begin
        bcd_q <= {adj[fsp_pkg::BCD_W-2:0], bin_q[fsp_pkg::ARG_W-1]};
        bin_q <= {bin_q[fsp_pkg::ARG_W-2:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  `FSP_ASSERT_SAME(a_start_idle, start_i, !busy_q, "conversion started while busy")
  `FSP_ASSERT_NEXT(a_start_busy, start_i, busy_q && !done_q, "start did not begin conversion")
  `FSP_ASSERT_SAME(a_top_digit, done_o, bcd_o[fsp_pkg::BCD_W-1 -: 4] <= 4'd4,
                   "top decimal digit out of range")

endmodule

FILE: design/format_string_printer.sv
// Streaming printf-style formatter. Each request carries either a format byte
// (operation 0) or an argument word (operation 1); ordinary bytes come out as
// characters, %i prints a signed decimal, %c the low byte, %x/%X the 32-bit hex
// value and %hx/%hX its low 16 bits, with leading zeros dropped. A NUL byte
// emits a terminator result and restarts the count for the next string. Each
// result reports the character, whether it fit in the buffer, its offset and the
// running count; buffer_size is written through cfg_we_i/cfg_buffer_size_i,
// which the user must do only while the block is idle; the block itself does
// not enforce it. A request that makes no result (a '%', a specifier letter or
// a stray argument) is taken and leaves the block ready again; after any other
// request the block emits one character per cycle while the output register
// is free, so a plain byte or a terminator gives one character and a %h echo
// three. Hex first runs the zero skip, one step per dropped leading zero, and
// every dropped zero is one character less. %i first runs the conversion in
// the bcd shift-and-add-3 unit (32 shifts, then the done flag), then skips and
// prints over ten digits as hex does, after a minus sign for a negative value.
// A finished character waits while the output register holds a result not yet
// taken. The block holds the next request off until the last character of the
// current one has been loaded into the output register; a result waiting there
// does not block the next request.
`include "format_string_printer_defines.svh"

module format_string_printer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsp_pkg::SIZE_W-1:0]    cfg_buffer_size_i,
  fsp_req_if.sink                       req_i,
  fsp_res_if.source                     res_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] ST_DABB = 2'd1;  // decimal conversion running
  localparam logic [1:0] ST_SKIP = 2'd2;  // drop leading zero digits
  localparam logic [1:0] ST_EMIT = 2'd3;  // one character per free output slot

  // parse phases
  localparam logic [1:0] PH_PLAIN   = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_PCT_H   = 2'd2;
  localparam logic [1:0] PH_WAIT    = 2'd3;

  logic [1:0]                state_q;
  logic [1:0]                phase_q;
  logic [1:0]                kind_q;
  logic                      upper_q;
  fsp_pkg::offset_t          room_q;
  fsp_pkg::offset_t          offset_q;
  logic [fsp_pkg::ARG_W-1:0] total_q;
  logic [fsp_pkg::SIZE_W-1:0] buf_size_q;

  // character source: up to three literal chars, then up to ten digits
  logic [3*fsp_pkg::CHAR_W-1:0] pre_q;
  logic [1:0]                   pre_n_q;
  logic [fsp_pkg::BCD_W-1:0]    dig_q;
  logic [3:0]                   left_q;
  logic                         term_q;

  // output register
  logic                         res_valid_q;
  fsp_pkg::char_t               res_char_q;
  logic                         res_stored_q;
  logic [fsp_pkg::POS_W-1:0]    res_pos_q;
  logic [fsp_pkg::ARG_W-1:0]    res_total_q;
  logic                         res_term_q;
  logic                         res_last_q;

  logic                         accept;
  logic                         arg_neg;
  logic [fsp_pkg::ARG_W-1:0]    arg_mag;
  logic                         bcd_start;
  logic                         bcd_done;
  logic [fsp_pkg::BCD_W-1:0]    bcd_val;
  logic                         emit_go;
  logic                         fits;
  logic                         is_last;
  fsp_pkg::char_t               cur_char;
  fsp_pkg::char_t               c_in;
  fsp_pkg::offset_t             size_w;

  assign accept    = req_i.valid && req_i.ready;
  assign c_in      = req_i.format_char;
  assign arg_neg   = req_i.argument[fsp_pkg::ARG_W-1];
  // magnitude formed unsigned, so the most negative value is fine
  assign arg_mag   = arg_neg ? (~req_i.argument + 32'd1) : req_i.argument;
  assign bcd_start = accept && req_i.operation && (phase_q == PH_WAIT)
                     && (kind_q == fsp_pkg::KIND_INT);

  fsp_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .value_i (arg_mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd_val)
  );

  assign emit_go  = (state_q == ST_EMIT) && (!res_valid_q || res_o.ready);
  assign fits     = room_q > fsp_pkg::offset_t'(1);
  assign cur_char = (pre_n_q != 2'd0) ? pre_q[3*fsp_pkg::CHAR_W-1 -: fsp_pkg::CHAR_W]
                    : fsp_pkg::digit_char(dig_q[fsp_pkg::BCD_W-1 -: 4], upper_q);
  assign is_last  = ((pre_n_q == 2'd1) && (left_q == 4'd0))
                    || ((pre_n_q == 2'd0) && (left_q == 4'd1));
  assign size_w   = fsp_pkg::offset_t'(cfg_buffer_size_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_PLAIN;
      kind_q       <= fsp_pkg::KIND_INT;
      upper_q      <= 1'b0;
      buf_size_q   <= '1;
      room_q       <= fsp_pkg::offset_t'({fsp_pkg::SIZE_W{1'b1}});
      offset_q     <= '0;
      total_q      <= '0;
      pre_q        <= '0;
      pre_n_q      <= '0;
      dig_q        <= '0;
      left_q       <= '0;
      term_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_char_q   <= '0;
      res_stored_q <= 1'b0;
      res_pos_q    <= '0;
      res_total_q  <= '0;
      res_term_q   <= 1'b0;
      res_last_q   <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pre_n_q <= 2'd0;
            left_q  <= 4'd0;
            term_q  <= 1'b0;
            if (req_i.operation) begin
              // argument word, ignored unless a specifier waits
              if (phase_q == PH_WAIT) begin
                phase_q <= PH_PLAIN;
                case (kind_q)
                  fsp_pkg::KIND_INT: begin
                    pre_q   <= {fsp_pkg::CH_MINUS, 16'h0000};
                    pre_n_q <= arg_neg ? 2'd1 : 2'd0;
                    left_q  <= 4'(fsp_pkg::BCD_DIGITS);
                    state_q <= ST_DABB;
                  end
                  fsp_pkg::KIND_CHAR: begin
                    pre_q   <= {req_i.argument[7:0], 16'h0000};
                    pre_n_q <= 2'd1;
                    state_q <= ST_EMIT;
                  end
                  fsp_pkg::KIND_HEX: begin
                    dig_q   <= {req_i.argument, 8'h00};
                    left_q  <= 4'd8;
                    state_q <= ST_SKIP;
                  end
                  default: begin
                    dig_q   <= {req_i.argument[15:0], 24'h000000};
                    left_q  <= 4'd4;
                    state_q <= ST_SKIP;
                  end
                endcase
              end
            end else begin
              phase_q <= PH_PLAIN;
              case (phase_q)
                PH_PERCENT: begin
                  if (c_in == fsp_pkg::CH_NUL) begin
                    term_q  <= 1'b1;
                    pre_q   <= '0;
                    pre_n_q <= 2'd1;
                    state_q <= ST_EMIT;
                  end else if (c_in == fsp_pkg::CH_I) begin
                    kind_q  <= fsp_pkg::KIND_INT;
                    phase_q <= PH_WAIT;
                  end else if (c_in == fsp_pkg::CH_C) begin
                    kind_q  <= fsp_pkg::KIND_CHAR;
                    phase_q <= PH_WAIT;
                  end else if (c_in inside {fsp_pkg::CH_X_LO, fsp_pkg::CH_X_UP}) begin
                    kind_q  <= fsp_pkg::KIND_HEX;
                    upper_q <= (c_in == fsp_pkg::CH_X_UP);
                    phase_q <= PH_WAIT;
                  end else if (c_in == fsp_pkg::CH_H) begin
                    phase_q <= PH_PCT_H;
                  end
                  // anything else is an unknown specifier and is dropped
                end
                PH_PCT_H: begin
                  if (c_in == fsp_pkg::CH_NUL) begin
                    term_q  <= 1'b1;
                    pre_q   <= '0;
                    pre_n_q <= 2'd1;
                    state_q <= ST_EMIT;
                  end else if (c_in inside {fsp_pkg::CH_X_LO, fsp_pkg::CH_X_UP}) begin
                    kind_q  <= fsp_pkg::KIND_SHORT;
                    upper_q <= (c_in == fsp_pkg::CH_X_UP);
                    phase_q <= PH_WAIT;
                  end else begin
                    // not a short hex: echo the three bytes
                    pre_q   <= {fsp_pkg::CH_PCT, fsp_pkg::CH_H, c_in};
                    pre_n_q <= 2'd3;
                    state_q <= ST_EMIT;
                  end
                end
                default: begin
                  // plain text, also drops a pending specifier
                  if (c_in == fsp_pkg::CH_NUL) begin
                    term_q  <= 1'b1;
                    pre_q   <= '0;
                    pre_n_q <= 2'd1;
                    state_q <= ST_EMIT;
                  end else if (c_in == fsp_pkg::CH_PCT) begin
                    phase_q <= PH_PERCENT;
                  end else begin
                    pre_q   <= {c_in, 16'h0000};
                    pre_n_q <= 2'd1;
                    state_q <= ST_EMIT;
                  end
                end
              endcase
            end
          end
        end

        ST_DABB: begin
          if (bcd_done) begin
            dig_q   <= bcd_val;
            state_q <= ST_SKIP;
          end
        end

        ST_SKIP: begin
          if ((left_q > 4'd1) && (dig_q[fsp_pkg::BCD_W-1 -: 4] == 4'd0)) begin
            dig_q  <= {dig_q[fsp_pkg::BCD_W-5:0], 4'h0};
            left_q <= left_q - 4'd1;
          end else begin
            state_q <= ST_EMIT;
          end
        end

        default: begin
          if (emit_go) begin
            res_valid_q <= 1'b1;
            res_char_q  <= cur_char;
            res_pos_q   <= fsp_pkg::POS_W'(offset_q);
            res_last_q  <= is_last;
            res_term_q  <= term_q;
            if (term_q) begin
              // terminator fits if any room is left, then start a fresh string
              res_stored_q <= (room_q != '0);
              res_total_q  <= total_q;
              total_q      <= '0;
              offset_q     <= '0;
              room_q       <= fsp_pkg::offset_t'(buf_size_q);
              term_q       <= 1'b0;
            end else begin
              res_stored_q <= fits;
              res_total_q  <= total_q + 32'd1;
              total_q      <= total_q + 32'd1;
              if (fits) begin
                room_q   <= room_q - fsp_pkg::offset_t'(1);
                offset_q <= offset_q + fsp_pkg::offset_t'(1);
              end
            end
            if (pre_n_q != 2'd0) begin
              pre_q   <= {pre_q[2*fsp_pkg::CHAR_W-1:0], 8'h00};
              pre_n_q <= pre_n_q - 2'd1;
            end else begin
              dig_q  <= {dig_q[fsp_pkg::BCD_W-5:0], 4'h0};
              left_q <= left_q - 4'd1;
            end
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
      endcase

      // buffer size write, room follows the current offset
      if (cfg_we_i) begin
        buf_size_q <= cfg_buffer_size_i;
        room_q     <= (size_w > offset_q) ? (size_w - offset_q) : '0;
      end
    end
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = res_valid_q;
  assign res_o.out_char      = res_char_q;
  assign res_o.stored        = res_stored_q;
  assign res_o.position      = res_pos_q;
  assign res_o.total_count   = res_total_q;
  assign res_o.is_terminator = res_term_q;
  assign res_o.last          = res_last_q;

  `FSP_ASSERT_NEXT(a_store_adv, emit_go && !term_q && fits && !cfg_we_i,
                   offset_q == fsp_pkg::offset_t'($past(offset_q) + 1'b1),
                   "stored character did not advance offset")
  `FSP_ASSERT_NEXT(a_term_clear, emit_go && term_q,
                   (total_q == '0) && (offset_q == '0) && res_term_q,
                   "terminator did not restart the string")
  `FSP_ASSERT_SAME(a_bcd_dabb, bcd_done, state_q == ST_DABB,
                   "decimal result outside conversion state")
  `FSP_ASSERT_SAME(a_skip_left, state_q == ST_SKIP, left_q != 4'd0,
                   "digit skip with no digits")

endmodule
